// ===== rtl/cbc_pkg.sv =====
// Shared types and constants of the cartridge bank controller.
// No dependencies; imported by every module of the block but cbc_fifo.
package cbc_pkg;

  // Widths fixed by the bus fields
  localparam int unsigned OFF_W     = 22;  // widest ROM offset incl. bank overflow
  localparam int unsigned SIZE_W    = 22;
  localparam int unsigned LOAD_W    = 21;
  localparam int unsigned RAMSUM_W  = 18;  // ram_bank * 0x2000 + address
  localparam int unsigned Q_DEPTH   = 4;   // front-to-back queue
  localparam int unsigned OUT_DEPTH = 4;   // result queue

  localparam logic [SIZE_W-1:0]   ROM_SIZE_RESET = 22'd262144;
  localparam logic [RAMSUM_W-1:0] ERAM_BASE      = 18'h0A000;
  localparam logic [3:0]          RAM_EN_KEY     = 4'hA;
  localparam logic [7:0]          MISS_BYTE      = 8'hFF;

  // Bus actions
  typedef enum logic [2:0] {
    ACT_ROM_RD   = 3'd0,
    ACT_CTRL_WR  = 3'd1,
    ACT_RAM_RD   = 3'd2,
    ACT_RAM_WR   = 3'd3,
    ACT_ROM_LOAD = 3'd4
  } action_t;

  // Cartridge types
  typedef enum logic [1:0] {
    CART_ROM_ONLY = 2'd0,
    CART_MBC1     = 2'd1,
    CART_MBC3     = 2'd2,
    CART_MBC5     = 2'd3
  } cart_type_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_CART_TYPE = 2'd0,
    CFG_ROM_SIZE  = 2'd1
  } cfg_index_t;

  // Work kinds handed from front to back
  typedef enum logic [1:0] {
    OP_ROM_RD = 2'd0,
    OP_RAM_RD = 2'd1,
    OP_RAM_WR = 2'd2,
    OP_ROM_WR = 2'd3
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         index;
    logic [SIZE_W-1:0]  value;
  } cfg_wr_t;

  typedef struct packed {
    op_t              op;
    logic             hit;
    logic [OFF_W-1:0] off;
    logic [7:0]       data;
  } q_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] byte_val;
  } result_t;

endpackage

// ===== rtl/cbc_fifo.sv =====
// Small register queue used between front and back and for results.
// Depends on nothing; generic width and depth.
module cbc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store item
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/cbc_front.sv =====
// Front end: accepts bus items, holds bank registers and configuration,
// maps addresses and queues work for the back end. Uses cbc_pkg.
module cbc_front import cbc_pkg::*; #(
  parameter int unsigned ERAM_BYTES = 32768,
  parameter int unsigned ROM_BYTES  = 262144
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_wr_t           cfg_wr,
  input  logic              push,
  input  logic [2:0]        action,
  input  logic [15:0]       address,
  input  logic [7:0]        data,
  input  logic [LOAD_W-1:0] load_address,
  input  logic              q_full,
  output logic              q_push,
  output q_entry_t          q_entry
);

  cart_type_t        cart_type;
  logic [SIZE_W-1:0] rom_len;
  logic              ram_enable;
  logic [6:0]        rom_bank;
  logic [1:0]        ram_bank;
  logic              banking_mode;

  logic              ram_enable_next;
  logic [6:0]        rom_bank_next;
  logic [1:0]        ram_bank_next;
  logic              banking_mode_next;

  logic              accept;
  logic              ctrl_wr;
  logic [SIZE_W-1:0] rom_limit;
  logic [7:0]        rom_upper;
  logic [OFF_W-1:0]  rom_off;
  logic              rom_hit;
  logic [RAMSUM_W-1:0] ram_total;
  logic [RAMSUM_W-1:0] ram_rel;
  logic              ram_hit;
  logic              load_ok;
  logic [4:0]        bank_lo;
  logic              entry_valid;

  assign accept  = push && !q_full;
  assign ctrl_wr = accept && (action == ACT_CTRL_WR) && (cart_type == CART_MBC1);
  assign q_push  = accept && entry_valid;

  // Map ROM address through the bank register
  always_comb begin
    rom_limit = (rom_len > SIZE_W'(ROM_BYTES)) ? SIZE_W'(ROM_BYTES) : rom_len;
    rom_upper = {1'b0, rom_bank} + {6'b0, address[15:14]} - 8'd1;
    if ((cart_type == CART_MBC1) && (address[15:14] != 2'b00)) begin
      rom_off = {rom_upper, address[13:0]};
    end else begin
      rom_off = {6'b0, address};
    end
    rom_hit = (rom_off < rom_limit);
  end

  // Map RAM address through the RAM bank
  always_comb begin
    ram_total = {3'b0, ram_bank, 13'b0} + {2'b0, address};
    ram_rel   = ram_total - ERAM_BASE;
    ram_hit   = ram_enable && (ram_total >= ERAM_BASE) &&
                (ram_rel < RAMSUM_W'(ERAM_BYTES));
    load_ok   = ({1'b0, load_address} < SIZE_W'(ROM_BYTES));
  end

  // Classify item into queued work
  always_comb begin
    entry_valid  = 1'b0;
    q_entry.op   = OP_ROM_RD;
    q_entry.hit  = 1'b0;
    q_entry.off  = rom_off;
    q_entry.data = data;
    unique case (action)
      ACT_ROM_RD: begin
        entry_valid = 1'b1;
        q_entry.op  = OP_ROM_RD;
        q_entry.hit = rom_hit;
      end
      ACT_RAM_RD: begin
        entry_valid = 1'b1;
        q_entry.op  = OP_RAM_RD;
        q_entry.hit = ram_hit;
        q_entry.off = OFF_W'(ram_rel);
      end
      ACT_RAM_WR: begin
        entry_valid = ram_hit;
        q_entry.op  = OP_RAM_WR;
        q_entry.hit = ram_hit;
        q_entry.off = OFF_W'(ram_rel);
      end
      ACT_ROM_LOAD: begin
        entry_valid = load_ok;
        q_entry.op  = OP_ROM_WR;
        q_entry.hit = load_ok;
        q_entry.off = OFF_W'(load_address);
      end
      default: begin
        entry_valid = 1'b0;
      end
    endcase
  end

  // Decode control write into bank register updates
  always_comb begin
    ram_enable_next   = ram_enable;
    rom_bank_next     = rom_bank;
    ram_bank_next     = ram_bank;
    banking_mode_next = banking_mode;
    bank_lo           = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
    unique case (address[15:13])
      3'd0: ram_enable_next = (data[3:0] == RAM_EN_KEY);
      3'd1: rom_bank_next   = {rom_bank[6:5], bank_lo};
      3'd2: begin
        if (!banking_mode) begin
          rom_bank_next = {data[1:0], rom_bank[4:0]};
        end else begin
          ram_bank_next = data[1:0];
        end
      end
      default: banking_mode_next = data[0];
    endcase
  end

  // Hold bank state
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable   <= 1'b0;
      rom_bank     <= 7'd1;
      ram_bank     <= 2'd0;
      banking_mode <= 1'b0;
    end else if (ctrl_wr) begin
      ram_enable   <= ram_enable_next;
      rom_bank     <= rom_bank_next;
      ram_bank     <= ram_bank_next;
      banking_mode <= banking_mode_next;
    end
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cart_type <= CART_ROM_ONLY;
      rom_len   <= ROM_SIZE_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        CFG_CART_TYPE: cart_type <= cart_type_t'(cfg_wr.value[1:0]);
        CFG_ROM_SIZE:  rom_len   <= cfg_wr.value;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/cbc_back.sv =====
// Back end: carries out queued work on the ROM image and external RAM,
// and queues read results. Uses cbc_pkg and cbc_fifo.
module cbc_back import cbc_pkg::*; #(
  parameter int unsigned ERAM_BYTES = 32768,
  parameter int unsigned ROM_BYTES  = 262144
) (
  input  logic       clk,
  input  logic       rst,
  input  q_entry_t   q_entry,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] read_data,
  output logic       in_range
);

  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);
  localparam int unsigned RAM_AW = $clog2(ERAM_BYTES);
  localparam int unsigned OCW    = $clog2(OUT_DEPTH+1);

  logic [7:0] rom_mem [ROM_BYTES];
  logic [7:0] ram_mem [ERAM_BYTES];
  logic [7:0] rom_q;
  logic [7:0] ram_q;

  logic           is_read;
  logic           credit_ok;
  logic           pend;
  logic           pend_ram;
  logic           pend_hit;
  result_t        res;
  result_t        out_head;
  logic           out_full;
  logic [OCW-1:0] out_count;

  // Issue a read only when the result queue has room for it
  always_comb begin
    case (q_entry.op) inside
      OP_ROM_RD, OP_RAM_RD: is_read = 1'b1;
      default:              is_read = 1'b0;
    endcase
  end

  assign credit_ok = ((OCW+1)'(out_count) + (OCW+1)'(pend)) < (OCW+1)'(OUT_DEPTH);
  assign q_pop     = !q_empty && (!is_read || credit_ok);

  // ROM image port
  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.op == OP_ROM_WR)) begin
      rom_mem[q_entry.off[ROM_AW-1:0]] <= q_entry.data;
    end
    rom_q <= rom_mem[q_entry.off[ROM_AW-1:0]];
  end

  // External RAM port
  always_ff @(posedge clk) begin
    if (q_pop && (q_entry.op == OP_RAM_WR)) begin
      ram_mem[q_entry.off[RAM_AW-1:0]] <= q_entry.data;
    end
    ram_q <= ram_mem[q_entry.off[RAM_AW-1:0]];
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= q_pop && is_read;
    end
  end

  always_ff @(posedge clk) begin
    pend_ram <= (q_entry.op == OP_RAM_RD);
    pend_hit <= q_entry.hit;
  end

  // Select stored byte or substitute on a miss
  always_comb begin
    res.hit      = pend_hit;
    res.byte_val = pend_hit ? (pend_ram ? ram_q : rom_q) : MISS_BYTE;
  end

  cbc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pend),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (out_head),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign read_data = out_head.byte_val;
  assign in_range  = out_head.hit && !out_full | out_head.hit;

endmodule

// ===== rtl/cartridge_bank_controller.sv =====
// Top level of the cartridge bank controller: front end, work queue and
// back end. Uses cbc_pkg, cbc_front, cbc_fifo and cbc_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | push / full        | action, address, data, load_address
//  result   | pop / empty        | read_data, in_range
//  config   | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item is accepted per cycle while the four-entry work queue has room.
// A read result goes from the work queue via the registered ROM or RAM read
// to the result queue. The single-port ROM and RAM arrays carry one access
// a cycle. rst is synchronous and clears bank registers, configuration and
// queues; ROM and RAM contents are undefined until written. full rises when
// the work queue fills, which happens when results are not popped.
module cartridge_bank_controller import cbc_pkg::*; #(
  parameter int unsigned ERAM_BYTES = 32768,
  parameter int unsigned ROM_BYTES  = 262144
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        action,
  input  logic [15:0]       address,
  input  logic [7:0]        data,
  input  logic [LOAD_W-1:0] load_address,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        read_data,
  output logic              in_range,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int unsigned QCW = $clog2(Q_DEPTH+1);

  cfg_wr_t        cfg_wr;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  q_entry_t       q_in;
  q_entry_t       q_out;
  logic [QCW-1:0] q_count;

  // Configuration is always taken
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.value = cfg_data;

  cbc_front #(
    .ERAM_BYTES (ERAM_BYTES),
    .ROM_BYTES  (ROM_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr       (cfg_wr),
    .push         (push),
    .action       (action),
    .address      (address),
    .data         (data),
    .load_address (load_address),
    .q_full       (full),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  cbc_fifo #(
    .WIDTH ($bits(q_entry_t)),
    .DEPTH (Q_DEPTH)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_in),
    .rd_en   (q_pop),
    .rd_data (q_out),
    .full    (full),
    .empty   (q_empty),
    .count   (q_count)
  );

  cbc_back #(
    .ERAM_BYTES (ERAM_BYTES),
    .ROM_BYTES  (ROM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_entry   (q_out),
    .q_empty   (q_empty || (q_count == '0)),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .read_data (read_data),
    .in_range  (in_range)
  );

endmodule

// ===== rtl/cbc_checker.sv =====
// Port-level checks of the cartridge bank controller, bound to the top.
// Uses cbc_pkg for widths.
module cbc_checker import cbc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              push,
  input logic              full,
  input logic [2:0]        action,
  input logic [15:0]       address,
  input logic [7:0]        data,
  input logic [LOAD_W-1:0] load_address,
  input logic              empty,
  input logic              pop,
  input logic [7:0]        read_data,
  input logic              in_range,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [1:0]        cfg_index,
  input logic [SIZE_W-1:0] cfg_data
);

  // Reset leaves both queues drained
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not drained after reset");

  // No result can show up right after reset is released
  a_no_early_result: assert property (@(posedge clk) (rst ##1 !rst) |=> empty)
    else $error("result appeared before any item could complete");

  // A miss always carries the substitute byte
  a_miss_byte: assert property (@(posedge clk) disable iff (rst)
      (!empty && !in_range) |-> (read_data == MISS_BYTE))
    else $error("missed read did not return 0xFF");

  // A waiting result stays put until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(in_range)))
    else $error("waiting result changed or vanished");

endmodule

bind cartridge_bank_controller cbc_checker u_checker (.*);
